FILE: sv/tccw_pkg.sv
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared widths, command and operation codes, and the operation record that
// travels from the front end to the back end of the text console writer.
// ----------------------------------------------------------------------------
package tccw_pkg;

  // Field widths
  localparam int CMD_W   = 2;
  localparam int GLYPH_W = 8;
  localparam int ATTR_W  = 8;
  localparam int CELL_W  = ATTR_W + GLYPH_W;
  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;

  // Input commands
  localparam logic [CMD_W-1:0] CMD_PUT_CHAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE_AT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ     = 2'd3;

  // Glyphs and attribute
  localparam logic [GLYPH_W-1:0] GLYPH_BLANK     = 8'h20;
  localparam logic [GLYPH_W-1:0] GLYPH_NEWLINE   = 8'h0A;
  localparam logic [GLYPH_W-1:0] GLYPH_BACKSPACE = 8'h08;
  localparam logic [ATTR_W-1:0]  RESET_ATTR      = 8'h0F;

  // Operations handed to the back end
  typedef logic [1:0] op_kind_t;
  localparam op_kind_t OP_NOP   = 2'd0;
  localparam op_kind_t OP_WRITE = 2'd1;
  localparam op_kind_t OP_CLEAR = 2'd2;
  localparam op_kind_t OP_READ  = 2'd3;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    op_kind_t           kind;
    logic               scroll;   // scroll up one row after the operation
    logic [COL_W-1:0]   col;      // logical column of the cell
    logic [ROW_W-1:0]   row;      // logical row of the cell
    logic [ATTR_W-1:0]  attr;     // attribute for written and blanked cells
    logic [GLYPH_W-1:0] glyph;
    logic [COL_W-1:0]   cur_col;  // cursor after the item
    logic [ROW_W-1:0]   cur_row;
  } op_t;

endpackage

FILE: sv/tccw_front.sv
// ----------------------------------------------------------------------------
// tccw_front
// Accepts items, owns the cursor and the attribute register, and turns each
// item into one back-end operation pushed into the queue.
// ----------------------------------------------------------------------------
module tccw_front import tccw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [CMD_W-1:0]   cmd,
  input  logic [GLYPH_W-1:0] char_code,
  input  logic [COL_W-1:0]   col,
  input  logic [ROW_W-1:0]   row,
  input  logic               cfg_we,
  input  logic [ATTR_W-1:0]  cfg_data,
  input  logic               q_full,
  output logic               q_push,
  output op_t                q_op
);

  localparam logic [COL_W:0] COL_LIMIT = (COL_W+1)'(COLUMNS);
  localparam logic [ROW_W:0] ROW_LIMIT = (ROW_W+1)'(ROWS);
  localparam logic [ROW_W:0] ROW_LAST  = (ROW_W+1)'(ROWS - 1);

  logic [ATTR_W-1:0] attr;
  logic [COL_W-1:0]  cur_col;
  logic [ROW_W-1:0]  cur_row;
  logic [COL_W-1:0]  cur_col_next;
  logic [ROW_W:0]    row_wide;
  logic [COL_W:0]    col_inc;
  logic [ROW_W:0]    row_inc;
  logic              pos_ok;
  op_t               op;

  assign in_stall = q_full;
  assign q_push   = in_valid & ~q_full;
  assign col_inc  = {1'b0, cur_col} + 1'b1;
  assign row_inc  = {1'b0, cur_row} + 1'b1;
  assign pos_ok   = ({1'b0, col} < COL_LIMIT) && ({1'b0, row} < ROW_LIMIT);

  // Classify the item and work out the cursor that follows it
  always_comb begin
    op.kind    = OP_NOP;
    op.scroll  = 1'b0;
    op.col     = col;
    op.row     = row;
    op.attr    = attr;
    op.glyph   = char_code;
    cur_col_next = cur_col;
    row_wide     = {1'b0, cur_row};
    unique case (cmd)
      CMD_PUT_CHAR: begin
        op.col = cur_col;
        op.row = cur_row;
        if (char_code == GLYPH_NEWLINE) begin
          cur_col_next = '0;
          row_wide     = row_inc;
        end else if (char_code == GLYPH_BACKSPACE) begin
          if (cur_col != '0) begin
            cur_col_next = cur_col - 1'b1;
            op.kind      = OP_WRITE;
            op.col       = cur_col - 1'b1;
            op.glyph     = GLYPH_BLANK;
          end
        end else begin
          op.kind = OP_WRITE;
          if (col_inc >= COL_LIMIT) begin
            cur_col_next = '0;
            row_wide     = row_inc;
          end else begin
            cur_col_next = col_inc[COL_W-1:0];
          end
        end
        // Past the bottom row: scroll and stay on the last row
        if (row_wide >= ROW_LIMIT) begin
          op.scroll = 1'b1;
          row_wide  = ROW_LAST;
        end
      end
      CMD_WRITE_AT: begin
        if (pos_ok) begin
          op.kind = OP_WRITE;
        end
      end
      CMD_CLEAR: begin
        op.kind      = OP_CLEAR;
        cur_col_next = '0;
        row_wide     = '0;
      end
      CMD_READ: begin
        if (pos_ok) begin
          op.kind = OP_READ;
        end
      end
      default: begin
        op.kind = OP_NOP;
      end
    endcase
    op.cur_col = cur_col_next;
    op.cur_row = row_wide[ROW_W-1:0];
  end

  assign q_op = op;

  // Hold attribute and cursor; advance the cursor on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      attr    <= RESET_ATTR;
      cur_col <= '0;
      cur_row <= '0;
    end else begin
      if (cfg_we) begin
        attr <= cfg_data;
      end
      if (q_push) begin
        cur_col <= op.cur_col;
        cur_row <= op.cur_row;
      end
    end
  end

endmodule

FILE: sv/tccw_queue.sv
// ----------------------------------------------------------------------------
// tccw_queue
// Short first-in first-out queue of operations between front and back.
// ----------------------------------------------------------------------------
module tccw_queue import tccw_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_op,
  output logic full,
  input  logic pop,
  output logic empty,
  output op_t  head_op
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);

  op_t           slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CNT_FULL);
  assign empty   = (count == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign head_op = slots[rd_ptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  // Advance pointers and track the fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: sv/tccw_back.sv
// ----------------------------------------------------------------------------
// tccw_back
// Carries out operations against the cell memory. Rows are addressed through
// a rotating base row, so a scroll moves the base. Each physical row has a
// blank mark and a blank attribute: a marked row reads as blank cells and is
// swept to blanks, one cell a cycle, on its first write.
// ----------------------------------------------------------------------------
module tccw_back import tccw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  output logic              q_pop,
  input  op_t               q_op,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CELL_W-1:0] cell_value,
  output logic [COL_W-1:0]  cursor_col,
  output logic [ROW_W-1:0]  cursor_row
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int RW    = $clog2(ROWS);
  localparam int AW    = $clog2(CELLS);
  localparam logic [RW:0]      ROW_COUNT = (RW+1)'(ROWS);
  localparam logic [RW-1:0]    ROW_TOP   = RW'(ROWS - 1);
  localparam logic [COL_W-1:0] COL_LAST  = COL_W'(COLUMNS - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_FILL = 2'd2;
  localparam logic [1:0] ST_READ = 2'd3;

  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rd_data;

  logic [1:0]        state;
  logic [1:0]        state_next;
  op_t               op_r;
  logic [RW-1:0]     prow;
  logic [RW-1:0]     base;
  logic [COL_W-1:0]  fill_col;
  logic [ROWS-1:0]   row_blank;
  logic [ATTR_W-1:0] row_attr [ROWS];
  logic              res_valid;

  logic [RW:0]       phys_sum;
  logic [RW-1:0]     phys_row;
  logic [COL_W-1:0]  col_sel;
  logic [AW-1:0]     addr;
  logic              mem_we;
  logic [CELL_W-1:0] mem_wdata;
  logic [CELL_W-1:0] row_blank_cell;
  logic              done;
  logic [CELL_W-1:0] result_value;

  assign q_pop = (state == ST_IDLE) && !q_empty && !res_valid;

  // Map the logical row onto the rotating base
  assign phys_sum = {1'b0, q_op.row[RW-1:0]} + {1'b0, base};
  assign phys_row = (phys_sum >= ROW_COUNT) ? RW'(phys_sum - ROW_COUNT) : phys_sum[RW-1:0];

  // Cell address of the current operation or sweep position
  assign col_sel        = (state == ST_FILL) ? fill_col : op_r.col;
  assign addr           = AW'(prow) * AW'(COLUMNS) + AW'(col_sel);
  assign row_blank_cell = {row_attr[prow], GLYPH_BLANK};

  // Select memory writes and detect the end of an operation
  always_comb begin
    mem_we       = 1'b0;
    mem_wdata    = {op_r.attr, op_r.glyph};
    done         = 1'b0;
    result_value = '0;
    state_next   = state;
    unique case (state)
      ST_IDLE: begin
        if (q_pop) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (op_r.kind == OP_WRITE && row_blank[prow]) begin
          state_next = ST_FILL;
        end else if (op_r.kind == OP_READ) begin
          state_next = ST_READ;
        end else begin
          mem_we     = (op_r.kind == OP_WRITE);
          done       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_FILL: begin
        mem_we = 1'b1;
        if (fill_col != op_r.col) begin
          mem_wdata = row_blank_cell;
        end
        if (fill_col == COL_LAST) begin
          done       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_READ: begin
        done         = 1'b1;
        result_value = row_blank[prow] ? row_blank_cell : rd_data;
        state_next   = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Cell memory: one write port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= mem_wdata;
    end
    rd_data <= mem[addr];
  end

  // Control: sequencer, base row, blank marks, result handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      base      <= '0;
      res_valid <= 1'b0;
      row_blank <= '1;
      for (int i = 0; i < ROWS; i++) begin
        row_attr[i] <= RESET_ATTR;
      end
    end else begin
      state <= state_next;
      if (res_valid && !out_stall) begin
        res_valid <= 1'b0;
      end
      if (done) begin
        res_valid <= 1'b1;
        if (op_r.kind == OP_CLEAR) begin
          row_blank <= '1;
          for (int i = 0; i < ROWS; i++) begin
            row_attr[i] <= op_r.attr;
          end
        end
        if (state == ST_FILL) begin
          row_blank[prow] <= 1'b0;
        end
        // Old top row becomes the new bottom row, blank
        if (op_r.scroll) begin
          row_blank[base] <= 1'b1;
          row_attr[base]  <= op_r.attr;
          base            <= (base == ROW_TOP) ? '0 : base + 1'b1;
        end
      end
    end
  end

  // Payload: current operation, sweep column, result
  always_ff @(posedge clk) begin
    if (q_pop) begin
      op_r <= q_op;
      prow <= phys_row;
    end
    if (state == ST_EXEC) begin
      fill_col <= '0;
    end else if (state == ST_FILL) begin
      fill_col <= fill_col + 1'b1;
    end
    if (done) begin
      cell_value <= result_value;
      cursor_col <= op_r.cur_col;
      cursor_row <= op_r.cur_row;
    end
  end

  assign out_valid = res_valid;

endmodule

FILE: sv/text_console_cursor_writer_core.sv
// ----------------------------------------------------------------------------
// text_console_cursor_writer_core
// Text-mode cell console: cursor-driven put char, positioned write, clear
// and read over a COLUMNS x ROWS store of attribute/glyph cells.
//
//   Port group   Direction  Handshake          Payload
//   in           sink       in_valid/in_stall  cmd, char_code, col, row
//   out          source     out_valid/out_stall cell_value, cursor_col, cursor_row
//   cfg          sink       cfg_we             cfg_data (text attribute)
//
// An item goes from the queue head through EXEC to its result, a read also
// through READ; a write into a row left blank by reset, clear or scroll goes
// through FILL, where the single write port sweeps that row one cell a cycle.
// Reset needs no pass over the memory: every row is marked blank at once.
// The front end keeps taking items while the back end works, until the
// two-entry queue fills; a stalled result holds the back end only.
// ----------------------------------------------------------------------------
module text_console_cursor_writer_core import tccw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [CMD_W-1:0]   cmd,
  input  logic [GLYPH_W-1:0] char_code,
  input  logic [COL_W-1:0]   col,
  input  logic [ROW_W-1:0]   row,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [CELL_W-1:0]  cell_value,
  output logic [COL_W-1:0]   cursor_col,
  output logic [ROW_W-1:0]   cursor_row,
  input  logic               cfg_we,
  input  logic [ATTR_W-1:0]  cfg_data
);

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  op_t  push_op;
  op_t  head_op;

  // Front end: classify items, track cursor
  tccw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .char_code (char_code),
    .col       (col),
    .row       (row),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_op      (push_op)
  );

  // Operation queue
  tccw_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_op (push_op),
    .full    (q_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .head_op (head_op)
  );

  // Back end: cell memory and results
  tccw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .q_op       (head_op),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cell_value (cell_value),
    .cursor_col (cursor_col),
    .cursor_row (cursor_row)
  );

endmodule

FILE: sv/tccw_checker.sv
// ----------------------------------------------------------------------------
// tccw_checker
// Port-level checks on the console writer result channel.
// ----------------------------------------------------------------------------
module tccw_checker import tccw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_stall,
  input logic [CELL_W-1:0] cell_value,
  input logic [COL_W-1:0]  cursor_col,
  input logic [ROW_W-1:0]  cursor_row
);

  localparam logic [COL_W:0] COL_LIMIT = (COL_W+1)'(COLUMNS);
  localparam logic [ROW_W:0] ROW_LIMIT = (ROW_W+1)'(ROWS);

  // No result right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  // Cursor column stays on the screen
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, cursor_col} < COL_LIMIT))
    else $error("cursor column off screen");

  // Cursor row stays on the screen
  a_row_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, cursor_row} < ROW_LIMIT))
    else $error("cursor row off screen");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(cell_value)
      && $stable(cursor_col) && $stable(cursor_row))
    else $error("stalled result changed");

endmodule

bind text_console_cursor_writer_core tccw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tccw_checker (.*);

FILE: tb/sv/text_console_cursor_writer_core_tb.sv
// ----------------------------------------------------------------------------
// text_console_cursor_writer_core_tb
// Self-checking bench for the text console writer. A cycle-free model of the
// screen store, cursor and text attribute predicts the cursor and read data
// of every accepted item. Directed tests hit the control glyphs, the
// position bounds, the attribute and clear. Random sessions of text, line
// breaks, wraps, scrolls, writes and reads then run under several attribute
// settings, with bursty input and a patterned output stall.
// ----------------------------------------------------------------------------
module text_console_cursor_writer_core_tb;
  import tccw_pkg::*;

  localparam int COLS           = 80;
  localparam int ROWS_N         = 25;
  localparam int CELLS          = COLS * ROWS_N;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_PRINTED    = 30;

  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  typedef struct {
    logic [CELL_W-1:0] cval;
    logic [COL_W-1:0]  ccol;
    logic [ROW_W-1:0]  crow;
  } console_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [CMD_W-1:0]   cmd = CMD_READ;
  logic [GLYPH_W-1:0] char_code = '0;
  logic [COL_W-1:0]   col = '0;
  logic [ROW_W-1:0]   row = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [CELL_W-1:0]  cell_value;
  logic [COL_W-1:0]   cursor_col;
  logic [ROW_W-1:0]   cursor_row;
  logic               cfg_we = 1'b0;
  logic [ATTR_W-1:0]  cfg_data = '0;

  // Console model state
  logic [CELL_W-1:0]  screen_model [CELLS];
  int                 model_col;
  int                 model_row;
  logic [ATTR_W-1:0]  model_attr;

  console_result_t    pending_results [$];
  int                 error_count = 0;
  int                 items_sent = 0;
  int                 burst_left = 1;
  int                 idle_cycles = 0;
  rx_mode_t           rx_mode = RX_FREE;
  int                 rx_left = 0;

  text_console_cursor_writer_core #(
    .COLUMNS(COLS),
    .ROWS   (ROWS_N)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .char_code (char_code),
    .col       (col),
    .row       (row),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cell_value(cell_value),
    .cursor_col(cursor_col),
    .cursor_row(cursor_row),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [CELL_W-1:0] blank_cell();
    return {model_attr, GLYPH_BLANK};
  endfunction

  function automatic logic [COL_W-1:0] rand_col();
    return COL_W'($urandom_range((1 << COL_W) - 1, 0));
  endfunction

  function automatic logic [ROW_W-1:0] rand_row();
    return ROW_W'($urandom_range((1 << ROW_W) - 1, 0));
  endfunction

  // Store a glyph at a position; drop it when out of range
  function automatic void model_put_cell(int x, int y, logic [GLYPH_W-1:0] g);
    if (x < COLS && y < ROWS_N) begin
      screen_model[y * COLS + x] = {model_attr, g};
    end
  endfunction

  // Advance the console model by one item and queue the expected result
  function automatic void predict_console(logic [CMD_W-1:0] c, logic [GLYPH_W-1:0] g,
                                          logic [COL_W-1:0] x, logic [ROW_W-1:0] y);
    console_result_t res;
    res.cval = '0;
    case (c)
      CMD_PUT_CHAR: begin
        if (g == GLYPH_NEWLINE) begin
          model_col = 0;
          model_row++;
        end else if (g == GLYPH_BACKSPACE) begin
          if (model_col > 0) begin
            model_col--;
            model_put_cell(model_col, model_row, GLYPH_BLANK);
          end
        end else begin
          model_put_cell(model_col, model_row, g);
          model_col++;
        end
        if (model_col >= COLS) begin
          model_col = 0;
          model_row++;
        end
        // Scroll up one row and blank the bottom row
        if (model_row >= ROWS_N) begin
          for (int i = 0; i < COLS * (ROWS_N - 1); i++) begin
            screen_model[i] = screen_model[i + COLS];
          end
          for (int i = COLS * (ROWS_N - 1); i < CELLS; i++) begin
            screen_model[i] = blank_cell();
          end
          model_row = ROWS_N - 1;
        end
      end
      CMD_WRITE_AT: begin
        model_put_cell(int'(x), int'(y), g);
      end
      CMD_CLEAR: begin
        for (int i = 0; i < CELLS; i++) begin
          screen_model[i] = blank_cell();
        end
        model_col = 0;
        model_row = 0;
      end
      default: begin
        if (x < COLS && y < ROWS_N) begin
          res.cval = screen_model[int'(y) * COLS + int'(x)];
        end
      end
    endcase
    res.ccol = COL_W'(model_col);
    res.crow = ROW_W'(model_row);
    pending_results.push_back(res);
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    error_count++;
    if (error_count <= MAX_PRINTED) begin
      $display("mismatch in %s: got 0x%0h, expected 0x%0h", what, got, want);
    end
  endtask

  // Offer one item, hold it until accepted, then maybe open a gap
  task automatic send_item(logic [CMD_W-1:0] c, logic [GLYPH_W-1:0] g,
                           logic [COL_W-1:0] x, logic [ROW_W-1:0] y);
    in_valid  <= 1'b1;
    cmd       <= c;
    char_code <= g;
    col       <= x;
    row       <= y;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_console(c, g, x, y);
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      if ($urandom_range(3, 0) == 0) begin
        repeat ($urandom_range(40, 5)) @(posedge clk);
      end else begin
        repeat ($urandom_range(4, 1)) @(posedge clk);
      end
      if ($urandom_range(7, 0) == 0) begin
        burst_left = $urandom_range(60, 30);
      end else begin
        burst_left = $urandom_range(12, 1);
      end
    end
  endtask

  task automatic put_glyph(logic [GLYPH_W-1:0] g);
    send_item(CMD_PUT_CHAR, g, rand_col(), rand_row());
  endtask

  task automatic read_cell(logic [COL_W-1:0] x, logic [ROW_W-1:0] y);
    send_item(CMD_READ, GLYPH_W'($urandom_range(255, 0)), x, y);
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic wait_for_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_attribute(logic [ATTR_W-1:0] value);
    wait_for_idle();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    model_attr = value;
    cfg_we   <= 1'b0;
  endtask

  // Reset contents, corners and reads outside the screen
  task automatic test_reset_state();
    read_cell(7'd0, 5'd0);
    read_cell(7'd79, 5'd24);
    read_cell(7'd80, 5'd0);
    read_cell(7'd127, 5'd31);
    read_cell(7'd0, 5'd25);
  endtask

  // High glyphs, backspace at and above column 0, newline
  task automatic test_put_char_rules();
    put_glyph(8'h48);
    put_glyph(8'hFF);
    put_glyph(8'h80);
    put_glyph(GLYPH_BACKSPACE);
    read_cell(7'd0, 5'd0);
    read_cell(7'd1, 5'd0);
    read_cell(7'd2, 5'd0);
    put_glyph(GLYPH_NEWLINE);
    put_glyph(GLYPH_BACKSPACE);
    put_glyph(8'h00);
    read_cell(7'd0, 5'd1);
  endtask

  // Positioned writes at the last cell and just past each bound
  task automatic test_write_at_bounds();
    send_item(CMD_WRITE_AT, 8'h7E, 7'd79, 5'd24);
    send_item(CMD_WRITE_AT, 8'h55, 7'd80, 5'd3);
    send_item(CMD_WRITE_AT, 8'hAA, 7'd0, 5'd25);
    send_item(CMD_WRITE_AT, 8'h11, 7'd127, 5'd31);
    read_cell(7'd79, 5'd24);
    read_cell(7'd0, 5'd4);
    read_cell(7'd80, 5'd3);
  endtask

  // New attribute on a written glyph, then clear and home
  task automatic test_attribute_and_clear();
    write_attribute(8'hF0);
    put_glyph(8'h5A);
    read_cell(7'd0, 5'd1);
    send_item(CMD_CLEAR, 8'h00, rand_col(), rand_row());
    read_cell(7'd0, 5'd0);
    read_cell(7'd79, 5'd24);
  endtask

  // Mostly text and line breaks so wraps and scrolls happen, mixed with
  // reads near the cursor, positioned writes, clears and raw noise
  task automatic test_random_session(int count);
    int stop_at;
    int roll;
    int k;
    int m;
    int y;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      roll = $urandom_range(99, 0);
      if (roll < 40) begin
        k = $urandom_range(10, 0);
        repeat (k) put_glyph(GLYPH_W'($urandom_range(255, 0)));
        put_glyph(GLYPH_NEWLINE);
      end else if (roll < 48) begin
        k = $urandom_range(130, 70);
        repeat (k) put_glyph(GLYPH_W'($urandom_range(255, 0)));
      end else if (roll < 55) begin
        k = $urandom_range(30, 5);
        repeat (k) put_glyph(GLYPH_NEWLINE);
      end else if (roll < 62) begin
        k = $urandom_range(4, 0);
        m = $urandom_range(6, 1);
        repeat (k) put_glyph(GLYPH_W'($urandom_range(255, 0)));
        repeat (m) put_glyph(GLYPH_BACKSPACE);
      end else if (roll < 80) begin
        k = $urandom_range(4, 1);
        repeat (k) begin
          m = $urandom_range(99, 0);
          if (m < 70) begin
            y = model_row - $urandom_range((model_row < 2) ? model_row : 2, 0);
            read_cell(COL_W'($urandom_range(COLS - 1, 0)), ROW_W'(y));
          end else if (m < 85) begin
            read_cell(COL_W'($urandom_range(COLS - 1, 0)),
                      ROW_W'($urandom_range(ROWS_N - 1, 0)));
          end else begin
            read_cell(rand_col(), rand_row());
          end
        end
      end else if (roll < 93) begin
        k = $urandom_range(3, 1);
        repeat (k) begin
          if ($urandom_range(9, 0) < 6) begin
            send_item(CMD_WRITE_AT, GLYPH_W'($urandom_range(255, 0)),
                      COL_W'($urandom_range(COLS - 1, 0)),
                      ROW_W'($urandom_range(ROWS_N - 1, 0)));
          end else begin
            send_item(CMD_WRITE_AT, GLYPH_W'($urandom_range(255, 0)),
                      rand_col(), rand_row());
          end
        end
      end else if (roll < 95) begin
        send_item(CMD_CLEAR, GLYPH_W'($urandom_range(255, 0)), rand_col(), rand_row());
      end else begin
        k = $urandom_range(4, 1);
        repeat (k) begin
          send_item(CMD_W'($urandom_range(3, 0)), GLYPH_W'($urandom_range(255, 0)),
                    rand_col(), rand_row());
        end
      end
    end
  endtask

  // Check each accepted result against the oldest expectation
  always @(posedge clk) begin : check_result
    console_result_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no item pending", cell_value, 0);
      end else begin
        want = pending_results.pop_front();
        if (cell_value !== want.cval) report_mismatch("cell_value", cell_value, want.cval);
        if (cursor_col !== want.ccol) report_mismatch("cursor_col", cursor_col, want.ccol);
        if (cursor_row !== want.crow) report_mismatch("cursor_row", cursor_row, want.crow);
      end
    end
  end

  // Output stall: switch among free, light, heavy and periodic stretches
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(3, 0));
      rx_left <= $urandom_range(300, 50);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_FREE:     out_stall <= 1'b0;
      RX_LIGHT:    out_stall <= ($urandom_range(3, 0) == 0);
      RX_HEAVY:    out_stall <= ($urandom_range(3, 0) != 0);
      default:     out_stall <= ((rx_left % 8) < 3);
    endcase
  end

  // End the run when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid === 1'b1 && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall === 1'b0)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    model_attr = RESET_ATTR;
    model_col  = 0;
    model_row  = 0;
    for (int i = 0; i < CELLS; i++) begin
      screen_model[i] = {RESET_ATTR, GLYPH_BLANK};
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_put_char_rules();
    test_write_at_bounds();
    test_attribute_and_clear();

    write_attribute(8'h00);
    test_random_session(150);
    write_attribute(8'hFF);
    test_random_session(150);
    write_attribute(ATTR_W'($urandom_range(255, 0)));
    test_random_session(150);
    write_attribute(RESET_ATTR);
    test_random_session(150);
    write_attribute(ATTR_W'($urandom_range(255, 0)));
    test_random_session(150);

    // Drain, then let the back end settle
    wait_for_idle();
    repeat (COLS + 20) @(posedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
